// ----- rtl/core/alcf_pkg.sv -----
// Shared constants, types and register codes for the ADC level-change flasher.
`timescale 1ns / 1ps

package alcf_pkg;

    // Number of quantized levels above zero
    localparam int LEVEL_COUNT = 6;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int PHASE_W  = 16;
    localparam int LEVEL_W  = 3;
    // Full internal level width, wide enough for LEVEL_COUNT itself
    localparam int LVL_W    = $clog2(LEVEL_COUNT + 1);

    // Reciprocal of LEVEL_COUNT for the segment width: floor(2^SHIFT / LEVEL_COUNT)
    localparam int RECIP_SHIFT = SAMPLE_W + 4;
    localparam int RECIP       = (1 << RECIP_SHIFT) / LEVEL_COUNT;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SAMPLE_W + RECIP_W;
    // Width for q * LEVEL_COUNT and the correction remainder
    localparam int MUL_W       = SAMPLE_W + 4;

    // Serial divider step counter
    localparam int CNT_W = $clog2(SAMPLE_W);

    // APB port
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    // Register indexes
    localparam logic [1:0] REG_NOISE_THR = 2'd0;
    localparam logic [1:0] REG_TOP_THR   = 2'd1;
    localparam logic [1:0] REG_ON_PHASE  = 2'd2;
    localparam logic [1:0] REG_FLASH_TOT = 2'd3;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] NOISE_THR_RST = SAMPLE_W'(1);
    localparam logic [SAMPLE_W-1:0] TOP_THR_RST   = SAMPLE_W'(700);
    localparam logic [PHASE_W-1:0]  ON_PHASE_RST  = PHASE_W'(75);
    localparam logic [PHASE_W-1:0]  FLASH_TOT_RST = PHASE_W'(150);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_DIV,
        ST_DONE
    } state_t;

    // Input transaction payload
    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic [TIME_W-1:0]   time_ms;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               indicator;
        logic               level_changed;
        logic               flash_active;
    } out_item_t;

endpackage

// ----- rtl/core/adc_level_change_flasher.sv -----
// Top level: ADC sample quantizer with level-change flash sequencer and APB registers.
`timescale 1ns / 1ps
// Processing: an accepted sample passes the segment width and divider load (ST_WIDTH),
//   the bit-serial divide (ST_DIV), the divider done flag, then update and output (ST_DONE).
// A new sample is taken only in ST_IDLE, after the previous result has been registered;
//   the divider works one quotient bit per cycle.
// A new sample is taken while the previous result still waits on m_ready.
// Reset (aresetn low, synchronous) clears the flash state and loads register defaults.

module adc_level_change_flasher (
    input  logic                         aclk,
    input  logic                         aresetn,
    // sample input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  alcf_pkg::in_item_t           s_data,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output alcf_pkg::out_item_t          m_data,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [alcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [alcf_pkg::PDATA_W-1:0] pwdata,
    output logic [alcf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    // Configuration registers
    logic [alcf_pkg::SAMPLE_W-1:0] noise_thr_reg;
    logic [alcf_pkg::SAMPLE_W-1:0] top_thr_reg;
    logic [alcf_pkg::PHASE_W-1:0]  on_phase_reg;
    logic [alcf_pkg::PHASE_W-1:0]  flash_tot_reg;
    logic                          cfg_wr;
    logic [1:0]                    cfg_idx;

    // Sequencer and datapath
    alcf_pkg::state_t              state_reg, state_next;
    logic [alcf_pkg::SAMPLE_W-1:0] diff_reg, diff_next;
    logic                          above_reg, above_next;
    logic [alcf_pkg::SAMPLE_W-1:0] range_reg, range_next;
    logic [alcf_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [alcf_pkg::TIME_W-1:0]   time_reg, time_next;
    logic                          ge_tot_reg, ge_tot_next;
    logic                          ge_on_reg, ge_on_next;

    // Flash state
    logic                          seen_first_reg, seen_first_next;
    logic [alcf_pkg::LVL_W-1:0]    stable_level_reg, stable_level_next;
    logic [alcf_pkg::LVL_W-1:0]    target_level_reg, target_level_next;
    logic                          flashing_reg, flashing_next;
    logic [alcf_pkg::TIME_W-1:0]   flash_start_reg, flash_start_next;
    logic                          ind_reg, ind_next;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    alcf_pkg::out_item_t           m_data_reg, m_data_next;

    // Combinational helpers
    logic [alcf_pkg::SAMPLE_W-1:0] range_c;
    logic [alcf_pkg::SAMPLE_W-1:0] q0;
    logic [alcf_pkg::MUL_W-1:0]    q0_mul;
    logic [alcf_pkg::MUL_W-1:0]    q0_rem;
    logic [alcf_pkg::SAMPLE_W-1:0] width_c;
    logic [alcf_pkg::TIME_W-1:0]   elapsed;
    logic                          div_start;
    logic                          div_done;
    logic [alcf_pkg::SAMPLE_W-1:0] div_quo;
    logic [alcf_pkg::SAMPLE_W:0]   lvl_sum;
    logic [alcf_pkg::LVL_W-1:0]    lvl_c;
    logic                          out_free;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_thr_reg <= alcf_pkg::NOISE_THR_RST;
            top_thr_reg   <= alcf_pkg::TOP_THR_RST;
            on_phase_reg  <= alcf_pkg::ON_PHASE_RST;
            flash_tot_reg <= alcf_pkg::FLASH_TOT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                alcf_pkg::REG_NOISE_THR: noise_thr_reg <= pwdata[alcf_pkg::SAMPLE_W-1:0];
                alcf_pkg::REG_TOP_THR:   top_thr_reg   <= pwdata[alcf_pkg::SAMPLE_W-1:0];
                alcf_pkg::REG_ON_PHASE:  on_phase_reg  <= pwdata[alcf_pkg::PHASE_W-1:0];
                alcf_pkg::REG_FLASH_TOT: flash_tot_reg <= pwdata[alcf_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            alcf_pkg::REG_NOISE_THR: prdata = alcf_pkg::PDATA_W'(noise_thr_reg);
            alcf_pkg::REG_TOP_THR:   prdata = alcf_pkg::PDATA_W'(top_thr_reg);
            alcf_pkg::REG_ON_PHASE:  prdata = alcf_pkg::PDATA_W'(on_phase_reg);
            alcf_pkg::REG_FLASH_TOT: prdata = alcf_pkg::PDATA_W'(flash_tot_reg);
            default:                 prdata = '0;
        endcase
    end

    // Working range; empty when top is not above noise
    assign range_c = (top_thr_reg > noise_thr_reg) ? (top_thr_reg - noise_thr_reg) : '0;

    // Segment width = range / LEVEL_COUNT by reciprocal, one-step correction, floor of 1
    assign q0      = prod_reg[alcf_pkg::RECIP_SHIFT +: alcf_pkg::SAMPLE_W];
    assign q0_mul  = alcf_pkg::MUL_W'(q0) * alcf_pkg::MUL_W'(alcf_pkg::LEVEL_COUNT);
    assign q0_rem  = alcf_pkg::MUL_W'(range_reg) - q0_mul;
    always_comb begin
        width_c = q0 + alcf_pkg::SAMPLE_W'(q0_rem >= alcf_pkg::MUL_W'(alcf_pkg::LEVEL_COUNT));
        if (width_c == '0) begin
            width_c = alcf_pkg::SAMPLE_W'(1);
        end
    end

    // Wrapping time since flash start
    assign elapsed = time_reg - flash_start_reg;

    // Quantized level from the divider quotient
    assign lvl_sum = {1'b0, div_quo} + 1'b1;
    always_comb begin
        if (!above_reg) begin
            lvl_c = '0;
        end else if (lvl_sum > (alcf_pkg::SAMPLE_W + 1)'(alcf_pkg::LEVEL_COUNT)) begin
            lvl_c = alcf_pkg::LVL_W'(alcf_pkg::LEVEL_COUNT);
        end else begin
            lvl_c = lvl_sum[alcf_pkg::LVL_W-1:0];
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == alcf_pkg::ST_WIDTH);

    alcf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (width_c),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer: next state, datapath capture and flash update
    always_comb begin
        state_next        = state_reg;
        diff_next         = diff_reg;
        above_next        = above_reg;
        range_next        = range_reg;
        prod_next         = prod_reg;
        time_next         = time_reg;
        ge_tot_next       = ge_tot_reg;
        ge_on_next        = ge_on_reg;
        seen_first_next   = seen_first_reg;
        stable_level_next = stable_level_reg;
        target_level_next = target_level_reg;
        flashing_next     = flashing_reg;
        flash_start_next  = flash_start_reg;
        ind_next          = ind_reg;
        m_data_next       = m_data_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        s_ready           = 1'b0;

        case (state_reg)
            alcf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    above_next = s_data.adc_sample > noise_thr_reg;
                    diff_next  = s_data.adc_sample - noise_thr_reg;
                    range_next = range_c;
                    prod_next  = alcf_pkg::PROD_W'(range_c)
                               * alcf_pkg::PROD_W'(alcf_pkg::RECIP);
                    time_next  = s_data.time_ms;
                    state_next = alcf_pkg::ST_WIDTH;
                end
            end
            alcf_pkg::ST_WIDTH: begin
                // divider loads width_c this cycle; settle the timing compares too
                ge_tot_next = elapsed >= alcf_pkg::TIME_W'(flash_tot_reg);
                ge_on_next  = elapsed >= alcf_pkg::TIME_W'(on_phase_reg);
                state_next  = alcf_pkg::ST_DIV;
            end
            alcf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = alcf_pkg::ST_DONE;
                end
            end
            alcf_pkg::ST_DONE: begin
                if (out_free) begin
                    // running flash: end it or drop into the off phase
                    if (flashing_reg) begin
                        if (ge_tot_reg) begin
                            flashing_next = 1'b0;
                            ind_next      = (target_level_reg != '0);
                        end else if (ge_on_reg) begin
                            ind_next = 1'b0;
                        end
                    end
                    m_data_next.level_changed = 1'b0;
                    // first sample only initializes; later changes start a flash
                    if (!seen_first_reg) begin
                        seen_first_next   = 1'b1;
                        stable_level_next = lvl_c;
                        target_level_next = lvl_c;
                        ind_next          = (lvl_c != '0);
                    end else if (!flashing_next && (lvl_c != stable_level_reg)) begin
                        stable_level_next         = lvl_c;
                        target_level_next         = lvl_c;
                        flashing_next             = 1'b1;
                        flash_start_next          = time_reg;
                        ind_next                  = 1'b1;
                        m_data_next.level_changed = 1'b1;
                    end
                    m_data_next.level        = lvl_c[alcf_pkg::LEVEL_W-1:0];
                    m_data_next.indicator    = ind_next;
                    m_data_next.flash_active = flashing_next;
                    m_valid_next             = 1'b1;
                    state_next               = alcf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = alcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= alcf_pkg::ST_IDLE;
            seen_first_reg   <= 1'b0;
            stable_level_reg <= '0;
            target_level_reg <= '0;
            flashing_reg     <= 1'b0;
            flash_start_reg  <= '0;
            ind_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            seen_first_reg   <= seen_first_next;
            stable_level_reg <= stable_level_next;
            target_level_reg <= target_level_next;
            flashing_reg     <= flashing_next;
            flash_start_reg  <= flash_start_next;
            ind_reg          <= ind_next;
            m_valid_reg      <= m_valid_next;
        end
        diff_reg   <= diff_next;
        above_reg  <= above_next;
        range_reg  <= range_next;
        prod_reg   <= prod_next;
        time_reg   <= time_next;
        ge_tot_reg <= ge_tot_next;
        ge_on_reg  <= ge_on_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result that reports a new flash must show that flash running
    a_change_flash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.level_changed |-> m_data_reg.flash_active)
        else $error("level change reported without active flash");

    // Divider completion only arrives while the sequencer waits for it
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == alcf_pkg::ST_DIV)
        else $error("divider done outside divide state");

    // An accepted transaction always proceeds to the width step
    a_accept_width: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == alcf_pkg::ST_WIDTH)
        else $error("accepted sample did not start processing");

    // Stored level never exceeds the level count
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stable_level_reg <= alcf_pkg::LVL_W'(alcf_pkg::LEVEL_COUNT))
        else $error("stored level out of range");

endmodule

// ----- rtl/core/alcf_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module alcf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [alcf_pkg::SAMPLE_W-1:0] dividend,
    input  logic [alcf_pkg::SAMPLE_W-1:0] divisor,
    output logic                          done,
    output logic [alcf_pkg::SAMPLE_W-1:0] quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [alcf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [alcf_pkg::SAMPLE_W-1:0] rem_reg, rem_next;
    logic [alcf_pkg::SAMPLE_W-1:0] quo_reg, quo_next;
    logic [alcf_pkg::SAMPLE_W-1:0] dvs_reg, dvs_next;
    logic [alcf_pkg::SAMPLE_W:0]   trial;
    logic [alcf_pkg::SAMPLE_W:0]   diff;

    // Shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[alcf_pkg::SAMPLE_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // quotient bits enter from the right as dividend bits leave on the left
            if (!diff[alcf_pkg::SAMPLE_W]) begin
                rem_next = diff[alcf_pkg::SAMPLE_W-1:0];
                quo_next = {quo_reg[alcf_pkg::SAMPLE_W-2:0], 1'b1};
            end else begin
                rem_next = trial[alcf_pkg::SAMPLE_W-1:0];
                quo_next = {quo_reg[alcf_pkg::SAMPLE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == alcf_pkg::CNT_W'(alcf_pkg::SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Remainder is reduced below the divisor once the quotient is complete
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && (dvs_reg != '0) |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

    // A new division is never launched over a running one
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Completion leaves the divider free
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider busy at completion");

endmodule

// ----- tb/sv/alcf_flash_checker.sv -----
// Checker for the level-change flasher: tracks registers, predicts each result, compares.
`timescale 1ns / 1ps

module alcf_flash_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  alcf_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  alcf_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [alcf_pkg::ADDR_W-1:0]   paddr,
    input  logic [alcf_pkg::PDATA_W-1:0]  pwdata,
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_seen,
    output int                            flash_starts
);

    // Register shadow
    int unsigned thr_noise;
    int unsigned thr_top;
    int unsigned on_ms;
    int unsigned total_ms;

    // Flasher state shadow
    logic                        primed;
    int unsigned                 stable_lv;
    int unsigned                 target_lv;
    logic                        flashing;
    logic [alcf_pkg::TIME_W-1:0] flash_t0;
    logic                        lamp;

    // Results still owed by the block, oldest first
    alcf_pkg::out_item_t pending_results[$];

    // Quantize one sample with the current thresholds (full level, not truncated)
    function automatic int unsigned level_of(input logic [alcf_pkg::SAMPLE_W-1:0] smp);
        int unsigned span;
        int unsigned seg;
        int unsigned lv;
        if (smp <= thr_noise)
            return 0;
        span = (thr_top > thr_noise) ? (thr_top - thr_noise) : 0;
        seg  = span / alcf_pkg::LEVEL_COUNT;
        if (seg == 0)
            seg = 1;
        lv = (smp - thr_noise) / seg + 1;
        if (lv > alcf_pkg::LEVEL_COUNT)
            lv = alcf_pkg::LEVEL_COUNT;
        return lv;
    endfunction

    // Advance the flash sequence by one sample and return the result it should give
    function automatic alcf_pkg::out_item_t advance_flash(input alcf_pkg::in_item_t smp);
        logic [alcf_pkg::TIME_W-1:0] elapsed;
        int unsigned                 lv;
        alcf_pkg::out_item_t         res;
        lv = level_of(smp.adc_sample);
        res.level_changed = 1'b0;
        // flash timing first: end of flash, or on phase over
        if (flashing) begin
            elapsed = smp.time_ms - flash_t0;
            if (elapsed >= total_ms) begin
                flashing = 1'b0;
                lamp     = (target_lv != 0);
            end else if (elapsed >= on_ms) begin
                lamp = 1'b0;
            end
        end
        // first sample only primes; later a change starts a flash if none runs
        if (!primed) begin
            primed    = 1'b1;
            stable_lv = lv;
            target_lv = lv;
            lamp      = (lv != 0);
        end else if (!flashing && lv != stable_lv) begin
            stable_lv         = lv;
            target_lv         = lv;
            flashing          = 1'b1;
            flash_t0          = smp.time_ms;
            lamp              = 1'b1;
            res.level_changed = 1'b1;
        end
        res.level        = alcf_pkg::LEVEL_W'(lv);
        res.indicator    = lamp;
        res.flash_active = flashing;
        return res;
    endfunction

    task automatic report_bad(input string why, input alcf_pkg::out_item_t want,
                              input alcf_pkg::out_item_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t: %s: expected level=%0d ind=%0b chg=%0b act=%0b, ",
                   $time, why, want.level, want.indicator, want.level_changed,
                   want.flash_active);
            $display("got level=%0d ind=%0b chg=%0b act=%0b",
                     got.level, got.indicator, got.level_changed, got.flash_active);
        end
    endtask

    always @(posedge aclk) begin
        alcf_pkg::out_item_t want;
        if (!aresetn) begin
            thr_noise = alcf_pkg::NOISE_THR_RST;
            thr_top   = alcf_pkg::TOP_THR_RST;
            on_ms     = alcf_pkg::ON_PHASE_RST;
            total_ms  = alcf_pkg::FLASH_TOT_RST;
            primed    = 1'b0;
            stable_lv = 0;
            target_lv = 0;
            flashing  = 1'b0;
            flash_t0  = '0;
            lamp      = 1'b0;
            pending_results.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    alcf_pkg::REG_NOISE_THR: thr_noise = pwdata[alcf_pkg::SAMPLE_W-1:0];
                    alcf_pkg::REG_TOP_THR:   thr_top   = pwdata[alcf_pkg::SAMPLE_W-1:0];
                    alcf_pkg::REG_ON_PHASE:  on_ms     = pwdata[alcf_pkg::PHASE_W-1:0];
                    alcf_pkg::REG_FLASH_TOT: total_ms  = pwdata[alcf_pkg::PHASE_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    want = '0;
                    report_bad("unexpected result", want, m_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.level !== want.level || m_data.indicator !== want.indicator ||
                        m_data.level_changed !== want.level_changed ||
                        m_data.flash_active !== want.flash_active)
                        report_bad("result mismatch", want, m_data);
                end
            end
            // sample transaction
            if (s_valid && s_ready) begin
                want = advance_flash(s_data);
                if (want.level_changed)
                    flash_starts++;
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/sv/adc_level_change_flasher_test.sv -----
// Testbench top for the ADC level-change flasher: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module adc_level_change_flasher_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 20;

    // Receiver stall modes
    localparam int RX_FREE   = 0;
    localparam int RX_SPARSE = 1;
    localparam int RX_LONG   = 2;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    alcf_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    alcf_pkg::out_item_t           m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [alcf_pkg::ADDR_W-1:0]   paddr;
    logic [alcf_pkg::PDATA_W-1:0]  pwdata;
    logic [alcf_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    int mismatches;
    int outstanding;
    int results_seen;
    int flash_starts;

    // Stimulus-side view of the registers, used only to aim samples at level edges and size time steps
    int unsigned                   cfg_noise;
    int unsigned                   cfg_top;
    int unsigned                   cfg_total;
    logic [alcf_pkg::TIME_W-1:0]   now_ms;
    logic [alcf_pkg::SAMPLE_W-1:0] last_smp;
    int                            samples_sent;
    int                            settings_used;
    int                            cycles;

    adc_level_change_flasher i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    alcf_flash_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .flash_starts (flash_starts)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: stall pattern that switches at random between free, sparse and long-stall modes
    int   rx_mode = RX_FREE;
    int   rx_mode_left = 0;
    int   rx_hold = 0;
    logic rx_next;

    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_FREE, RX_LONG);
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        rx_next = m_ready;
        if (rx_hold != 0) begin
            rx_hold--;
        end else begin
            case (rx_mode)
                RX_FREE:   rx_next = 1'b1;
                RX_SPARSE: rx_next = ($urandom_range(0, 3) != 0);
                default: begin
                    rx_next = !m_ready;
                    rx_hold = $urandom_range(0, 40);
                end
            endcase
        end
        m_ready <= rx_next;
    end

    function automatic alcf_pkg::in_item_t sample_at(input int unsigned smp,
                                                     input logic [alcf_pkg::TIME_W-1:0] t);
        alcf_pkg::in_item_t it;
        it.adc_sample = alcf_pkg::SAMPLE_W'(smp);
        it.time_ms    = t;
        return it;
    endfunction

    // Present one sample at a falling edge and hold it until the block takes it
    task automatic push_sample(input alcf_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
        samples_sent++;
        last_smp = it.adc_sample;
        @(negedge aclk);
    endtask

    // APB write: setup phase, access phase, then idle
    task automatic write_reg(input logic [1:0] idx, input logic [alcf_pkg::PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input int unsigned noise, input int unsigned top,
                                 input int unsigned on_len, input int unsigned total_len);
        write_reg(alcf_pkg::REG_NOISE_THR, noise);
        write_reg(alcf_pkg::REG_TOP_THR, top);
        write_reg(alcf_pkg::REG_ON_PHASE, on_len);
        write_reg(alcf_pkg::REG_FLASH_TOT, total_len);
        cfg_noise = noise & 32'h3FF;
        cfg_top   = top & 32'h3FF;
        cfg_total = total_len & 32'hFFFF;
        settings_used++;
    endtask

    // Drain: all results back, then let the pipeline go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Next random sample: level-edge values, repeats of the last sample and steady time steps,
    // with random values, backward steps, wraps and arbitrary timestamps mixed in
    task automatic next_sample(output alcf_pkg::in_item_t it);
        int unsigned span;
        int unsigned seg;
        int          v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            now_ms = $urandom;
        else if (pick < 7)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else if (pick < 10)
            now_ms = now_ms - $urandom_range(0, 50);
        else
            now_ms = now_ms + $urandom_range(0, cfg_total / 3 + 2);

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            v = $urandom_range(0, 1023);
        end else if (pick < 55) begin
            v = last_smp;
        end else begin
            span = (cfg_top > cfg_noise) ? (cfg_top - cfg_noise) : 0;
            seg  = span / alcf_pkg::LEVEL_COUNT;
            if (seg == 0)
                seg = 1;
            v = int'(cfg_noise) + $urandom_range(0, alcf_pkg::LEVEL_COUNT) * int'(seg)
                + $urandom_range(0, 2) - 1;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
        end
        it = sample_at(v, now_ms);
    endtask

    // Random samples sent in bursts with random gaps
    task automatic run_random(input int count);
        alcf_pkg::in_item_t it;
        int                 done;
        int                 burst;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && done < count; i++) begin
                next_sample(it);
                push_sample(it);
                done++;
            end
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(negedge aclk);
            end
        end
        settle();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_noise    = alcf_pkg::NOISE_THR_RST;
        cfg_top      = alcf_pkg::TOP_THR_RST;
        cfg_total    = alcf_pkg::FLASH_TOT_RST;
        now_ms       = '0;
        last_smp     = '0;
        samples_sent = 0;
        settings_used = 1;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: priming, flash phases, change ignored mid-flash,
        // flash end and restart in one step, time wrap and backward time
        push_sample(sample_at(500, 32'd0));
        push_sample(sample_at(1023, 32'd10));
        push_sample(sample_at(0, 32'd20));
        push_sample(sample_at(0, 32'd85));
        push_sample(sample_at(0, 32'd160));
        push_sample(sample_at(0, 32'd400));
        push_sample(sample_at(1, 32'd401));
        push_sample(sample_at(2, 32'd402));
        push_sample(sample_at(2, 32'hFFFF_FFC0));
        push_sample(sample_at(700, 32'hFFFF_FFE0));
        push_sample(sample_at(700, 32'h0000_0010));
        push_sample(sample_at(700, 32'h0000_0040));
        push_sample(sample_at(1023, 32'hFFFF_FFFF));
        push_sample(sample_at(1023, 32'h0000_0080));
        settle();

        // On phase not shorter than the whole flash: off phase skipped
        apply_setting(alcf_pkg::NOISE_THR_RST, alcf_pkg::TOP_THR_RST, 100, 50);
        push_sample(sample_at(300, 32'd1000));
        push_sample(sample_at(300, 32'd1040));
        push_sample(sample_at(300, 32'd1050));
        push_sample(sample_at(0, 32'd1060));
        push_sample(sample_at(0, 32'd1200));
        settle();

        // Extremes of the thresholds and timings
        apply_setting(0, 1023, 0, 0);
        run_random(100);
        apply_setting(1023, 0, 0, 65535);
        run_random(30);
        apply_setting(500, 500, 20, 40);
        run_random(90);
        apply_setting(0, 5, 3, 7);
        run_random(90);
        apply_setting(1, 700, 65535, 65535);
        run_random(90);
        apply_setting(1023, 1023, 65535, 0);
        run_random(30);

        // Random settings
        for (int p = 0; p < 6; p++) begin
            if ($urandom_range(0, 3) == 0)
                apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                apply_setting($urandom_range(0, 200), $urandom_range(300, 1023),
                              $urandom_range(0, 300), $urandom_range(0, 300));
            run_random(80);
        end

        $display("Run covered %0d samples under %0d register settings.",
                 samples_sent, settings_used);
        $display("Checked %0d results, %0d of them starting a flash.",
                 results_seen, flash_starts);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
